>>> design/stef_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stef_pkg: shared types and constants of the spanning tree edge filter
// Vertex and label widths, the queue entry passed from front to back, and
// the clamp that turns the vertex count register into the count in use.
// ----------------------------------------------------------------------------
package stef_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VIDX_W       = 6;    // vertex index and label width
    localparam int VCNT_W       = 7;    // vertex count register width
    localparam int CNT_W        = 6;    // tree edge count width
    localparam int COUNT_MAX    = 63;   // tree edge count saturates here
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = 1;
    localparam int QCNT_W       = 2;

    typedef logic [VIDX_W-1:0] t_vidx;
    typedef logic [VCNT_W-1:0] t_vcnt;
    typedef logic [CNT_W-1:0]  t_cnt;

    // class of an item as decided by the front part
    typedef enum logic [1:0] {
        OP_START,
        OP_BAD,
        OP_EDGE
    } t_op;

    typedef struct packed {
        t_op   op;
        t_vidx va;
        t_vidx vb;
    } t_qent;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // vertex count clamped to the label store depth
    function automatic t_vcnt eff_count(input t_vcnt vc);
        if (vc > VCNT_W'(MAX_VERTICES)) begin
            return VCNT_W'(MAX_VERTICES);
        end
        return vc;
    endfunction

endpackage

>>> design/stef_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stef_if: item channels of the spanning tree edge filter
// Valid/ready channels for candidate edge items and for result items.
// ----------------------------------------------------------------------------
interface stef_in_if import stef_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  kind;
    t_vidx vertex_a;
    t_vidx vertex_b;

    modport source (output valid, output kind, output vertex_a, output vertex_b,
                    input ready);
    modport sink   (input valid, input kind, input vertex_a, input vertex_b,
                    output ready);
endinterface

interface stef_out_if import stef_pkg::*; ();
    logic valid;
    logic ready;
    logic accepted;
    t_cnt tree_edges;
    logic tree_complete;
    logic bad_vertex;

    modport source (output valid, output accepted, output tree_edges,
                    output tree_complete, output bad_vertex, input ready);
    modport sink   (input valid, input accepted, input tree_edges,
                    input tree_complete, input bad_vertex, output ready);
endinterface

>>> design/stef_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stef_front: item intake and classification
// Accepts an item while the queue has room and tags it as a start, an edge
// with an out-of-range endpoint, or an edge to be looked up.
// ----------------------------------------------------------------------------
module stef_front import stef_pkg::*; (
    stef_in_if.sink i_item,
    input  t_vcnt   i_vertex_count,
    input  t_qstat  i_qstat,
    output logic    o_push,
    output t_qent   o_ent
);

    t_vcnt vc_eff;
    logic  bad;

    assign i_item.ready = !i_qstat.full;
    assign o_push       = i_item.valid && !i_qstat.full;

    // range check against the count in use
    assign vc_eff = eff_count(i_vertex_count);
    assign bad    = ({1'b0, i_item.vertex_a} >= vc_eff) ||
                    ({1'b0, i_item.vertex_b} >= vc_eff);

    always_comb begin
        o_ent.va = i_item.vertex_a;
        o_ent.vb = i_item.vertex_b;
        if (!i_item.kind) begin
            o_ent.op = OP_START;
        end else if (bad) begin
            o_ent.op = OP_BAD;
        end else begin
            o_ent.op = OP_EDGE;
        end
    end

endmodule

>>> design/stef_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stef_queue: classified item queue
// Two-entry FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module stef_queue import stef_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_qent  i_push_ent,
    input  logic   i_pop,
    output t_qent  o_head,
    output t_qstat o_stat
);

    t_qent              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QCNT_W-1:0]  r_cnt;

    assign o_head       = r_mem[r_rptr];
    assign o_stat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_ent;
        end
    end

endmodule

>>> design/stef_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stef_back: component label store and relabel sequencer
// Looks up both endpoint labels, walks the whole label memory to merge two
// components on an accepted edge, keeps the tree edge count and registers
// the result item.
// ----------------------------------------------------------------------------
module stef_back import stef_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_qent       i_head,
    input  t_qstat      i_qstat,
    output logic        o_pop,
    input  t_vcnt       i_vertex_count,
    stef_out_if.source  o_result
);

    localparam int IDX_W = VIDX_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_WALK,
        S_RESULT
    } t_state;

    t_state r_state, n_state;
    t_vidx  r_la, n_la;
    t_vidx  r_lb, n_lb;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic   r_pend, n_pend;
    t_cnt   r_count, n_count;
    logic   r_acc, n_acc;
    logic   r_bad, n_bad;
    logic   r_out_valid, n_out_valid;
    logic   r_out_acc, n_out_acc;
    t_cnt   r_out_cnt, n_out_cnt;
    logic   r_out_cmp, n_out_cmp;
    logic   r_out_bad, n_out_bad;

    // label memory, per-entry valid bits and registered read ports
    t_vidx  mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_vld;
    t_vidx  r_rd_a, r_rd_b;
    t_vidx  r_rd_addr_a, r_rd_addr_b;
    logic   r_rd_vld_a, r_rd_vld_b;

    t_vidx  rd_addr_a, rd_addr_b;
    logic   wr_en;
    logic   clr;
    t_vidx  eff_a, eff_b;
    logic   walk_end;
    t_vcnt  vc_eff;

    // an entry never written since the last start holds its own index
    assign eff_a    = r_rd_vld_a ? r_rd_a : r_rd_addr_a;
    assign eff_b    = r_rd_vld_b ? r_rd_b : r_rd_addr_b;
    assign walk_end = (r_idx == IDX_W'(MAX_VERTICES));
    assign vc_eff   = eff_count(i_vertex_count);

    // next-state logic
    always_comb begin
        n_state     = r_state;
        n_la        = r_la;
        n_lb        = r_lb;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_count     = r_count;
        n_acc       = r_acc;
        n_bad       = r_bad;
        n_out_valid = r_out_valid;
        n_out_acc   = r_out_acc;
        n_out_cnt   = r_out_cnt;
        n_out_cmp   = r_out_cmp;
        n_out_bad   = r_out_bad;
        o_pop       = 1'b0;
        rd_addr_a   = i_head.va;
        rd_addr_b   = i_head.vb;
        wr_en       = 1'b0;
        clr         = 1'b0;

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop = 1'b1;
                    n_acc = 1'b0;
                    n_bad = 1'b0;
                    unique case (i_head.op)
                        OP_START: begin
                            clr     = 1'b1;
                            n_count = '0;
                            n_state = S_RESULT;
                        end
                        OP_BAD: begin
                            n_bad   = 1'b1;
                            n_state = S_RESULT;
                        end
                        OP_EDGE: begin
                            n_state = S_CMP;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CMP: begin
                if (eff_a != eff_b) begin
                    n_la    = eff_a;
                    n_lb    = eff_b;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_state = S_WALK;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_WALK: begin
                // read entry idx while writing back the entry read last cycle
                rd_addr_a = r_idx[VIDX_W-1:0];
                n_pend    = !walk_end;
                if (!walk_end) begin
                    n_idx = r_idx + IDX_W'(1);
                end
                if (r_pend && (eff_a == r_lb)) begin
                    wr_en = 1'b1;
                end
                if (walk_end && !r_pend) begin
                    if (r_count != CNT_W'(COUNT_MAX)) begin
                        n_count = r_count + CNT_W'(1);
                    end
                    n_acc   = 1'b1;
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_out_acc   = r_acc;
                    n_out_cnt   = r_count;
                    n_out_cmp   = (({1'b0, r_count} + VCNT_W'(1)) >= vc_eff);
                    n_out_bad   = r_bad;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_la      <= n_la;
        r_lb      <= n_lb;
        r_idx     <= n_idx;
        r_acc     <= n_acc;
        r_bad     <= n_bad;
        r_out_acc <= n_out_acc;
        r_out_cnt <= n_out_cnt;
        r_out_cmp <= n_out_cmp;
        r_out_bad <= n_out_bad;
    end

    // valid bits: a start item returns every vertex to its own component
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[r_rd_addr_a] <= 1'b1;
        end
    end

    // label memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_rd_addr_a] <= r_la;
        end
        r_rd_a      <= mem[rd_addr_a];
        r_rd_b      <= mem[rd_addr_b];
        r_rd_addr_a <= rd_addr_a;
        r_rd_addr_b <= rd_addr_b;
        r_rd_vld_a  <= r_vld[rd_addr_a];
        r_rd_vld_b  <= r_vld[rd_addr_b];
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.accepted      = r_out_acc;
    assign o_result.tree_edges    = r_out_cnt;
    assign o_result.tree_complete = r_out_cmp;
    assign o_result.bad_vertex    = r_out_bad;

endmodule

>>> design/spanning_tree_edge_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spanning_tree_edge_filter: Kruskal edge acceptance over sorted edges
// Each input item gives exactly one result item. A start item clears all
// components at once (no clearing pass after reset or start). An edge with an
// out-of-range endpoint, or with both ends already in one component, is
// rejected without a walk. An accepted edge starts the relabel walk, which
// reads every entry of the label memory through one read port, one per cycle.
// A two-entry queue lets the block take further items during a walk, and a
// registered output holds a result until it is taken. vertex_count is set
// through the APB port at address 0 and must only be written while idle.
// ----------------------------------------------------------------------------
module spanning_tree_edge_filter import stef_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stef_in_if.sink     i_item,
    stef_out_if.source  o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_VERTEX_COUNT = 1'b0;

    t_vcnt  r_vertex_count;
    logic   push;
    logic   pop;
    t_qent  push_ent;
    t_qent  head;
    t_qstat qstat;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VCNT_W'(MAX_VERTICES);
        end else if (psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT)) begin
            r_vertex_count <= pwdata[VCNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {{(32-VCNT_W){1'b0}}, r_vertex_count}
                                                  : 32'd0;

    stef_front u_front (
        .i_item         (i_item),
        .i_vertex_count (r_vertex_count),
        .i_qstat        (qstat),
        .o_push         (push),
        .o_ent          (push_ent)
    );

    stef_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_ent (push_ent),
        .i_pop      (pop),
        .o_head     (head),
        .o_stat     (qstat)
    );

    stef_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_qstat        (qstat),
        .o_pop          (pop),
        .i_vertex_count (r_vertex_count),
        .o_result       (o_result)
    );

endmodule

>>> design/stef_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stef_checker: port-level checks of the spanning tree edge filter
// Watches the result channel and the consistency of result fields.
// ----------------------------------------------------------------------------
module stef_checker import stef_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic i_ready,
    input logic i_accepted,
    input t_cnt i_tree_edges,
    input logic i_tree_complete,
    input logic i_bad_vertex
);

    // a stalled result item stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result valid dropped while stalled");

    // a stalled result item keeps its fields
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable({i_accepted, i_tree_edges,
                                         i_tree_complete, i_bad_vertex}))
        else $error("result fields changed while stalled");

    // an accepted edge always leaves a nonzero tree edge count
    a_acc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_accepted |-> (i_tree_edges != '0))
        else $error("accepted edge with zero tree edge count");

    // a bad endpoint never enters the tree
    a_bad_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_bad_vertex |-> !i_accepted)
        else $error("bad vertex edge reported as accepted");

endmodule

bind spanning_tree_edge_filter stef_checker u_stef_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_result.valid),
    .i_ready         (o_result.ready),
    .i_accepted      (o_result.accepted),
    .i_tree_edges    (o_result.tree_edges),
    .i_tree_complete (o_result.tree_complete),
    .i_bad_vertex    (o_result.bad_vertex)
);
